>>> design/pidfd_pkg.sv
// shared types, register codes and constants for the filtered-derivative pid block
// no dependencies
package pidfd_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_DEF  = 16;
  localparam int SUM_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [SUM_W-1:0] WIDE_LIM = 64'h2000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_OUT_LOWER   = 3'd3,
    REG_OUT_UPPER   = 3'd4,
    REG_INTEG_LOWER = 3'd5,
    REG_INTEG_UPPER = 3'd6,
    REG_FILTER_TAU  = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTEG,
    ST_RAW,
    ST_ALPHA,
    ST_FILT,
    ST_PROP,
    ST_INTG,
    ST_DERV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic        [DATA_W-1:0] step_time;
    logic signed [DATA_W-1:0] target;
    logic                     target_changed;
    logic                     clear_state;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     held;
  } out_word_t;

  function automatic logic signed [SUM_W-1:0] clamp_wide(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lo,
    input logic signed [SUM_W-1:0] hi
  );
    logic signed [SUM_W-1:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

>>> design/pid_controller_filtered_derivative.sv
// top level: config registers, controller state, step sequencer and output register
// depends on pidfd_pkg, pidfd_mul, pidfd_div
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid_i/in_ready_o   | in_word_i  (in_word_t)
//  out     | from block| out_valid_o/out_ready_i | out_word_o (out_word_t)
//  cfg     | to block  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a step runs up to five serial multiplies (one multiplier bit a cycle) and up to two
// restoring divisions, the second division and one multiply only with the filter on;
// a rejected step (zero step_time) skips them and is passed on as held. a new word is
// taken once the sequencer is back in idle and no cfg write is offered, while the last
// result may still sit in the output register. reset leaves gains at zero, limits at
// their extremes and the controller state cleared.
module pid_controller_filtered_derivative import pidfd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int W  = DATA_W;
  localparam int MW = W + 1;
  localparam int QW = W + FRAC_BITS;
  localparam logic [QW-1:0] RAW_MAX = QW'({(W-1){1'b1}});

  logic signed [W-1:0] kp_q, kp_d, ki_q, ki_d, kd_q, kd_d;
  logic signed [W-1:0] olo_q, olo_d, ohi_q, ohi_d, ilo_q, ilo_d, ihi_q, ihi_d;
  logic        [W-1:0] tau_q, tau_d;
  logic signed [W-1:0] integ_q, integ_d, deriv_q, deriv_d, prev_q, prev_d, last_q, last_d;
  logic                pv_q, pv_d;
  logic signed [W-1:0] smp_q, smp_d, raw_q, raw_d;
  logic        [W-1:0] dt_q, dt_d;
  logic signed [W:0]   err_q, err_d, alpha_q, alpha_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                held_q, held_d, run_q, run_d;
  state_e              state_q, state_d;
  logic                ovalid_q, ovalid_d;
  out_word_t           oword_q, oword_d;

  logic                    mul_start, mul_done, div_start, div_done;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [SUM_W-1:0] mul_res, acc_w;
  logic        [W-1:0]     div_num;
  logic        [W:0]       div_den;
  logic        [QW-1:0]    div_quo;
  logic signed [W:0]       dif;
  logic        [W-1:0]     dif_mag, raw_mag;
  logic signed [W-1:0]     raw_val, cfg_val;

  assign dif     = $signed({prev_q[W-1], prev_q}) - $signed({smp_q[W-1], smp_q});
  assign dif_mag = dif[W] ? W'(~dif + 1'b1) : dif[W-1:0];
  assign raw_mag = (div_quo > RAW_MAX) ? RAW_MAX[W-1:0] : div_quo[W-1:0];
  assign raw_val = dif[W] ? -$signed(raw_mag) : $signed(raw_mag);
  assign cfg_val = $signed(cfg_data_i);

  always_comb begin
    mul_a = $signed({kp_q[W-1], kp_q});
    mul_b = err_q;
    unique case (state_q)
      ST_INTEG: begin
        mul_a = err_q;
        mul_b = $signed({1'b0, dt_q});
      end
      ST_FILT: begin
        mul_a = alpha_q;
        mul_b = $signed({raw_q[W-1], raw_q}) - $signed({deriv_q[W-1], deriv_q});
      end
      ST_INTG: begin
        mul_a = $signed({ki_q[W-1], ki_q});
        mul_b = $signed({integ_q[W-1], integ_q});
      end
      ST_DERV: begin
        mul_a = $signed({kd_q[W-1], kd_q});
        mul_b = $signed({deriv_q[W-1], deriv_q});
      end
      default: begin
      end
    endcase
  end

  assign div_num = (state_q == ST_ALPHA) ? dt_q : dif_mag;
  assign div_den = (state_q == ST_ALPHA) ? ({1'b0, tau_q} + {1'b0, dt_q}) : {1'b0, dt_q};

  assign mul_start = !run_q && (state_q == ST_INTEG || state_q == ST_FILT ||
                                state_q == ST_PROP || state_q == ST_INTG ||
                                state_q == ST_DERV);
  assign div_start = !run_q && (state_q == ST_RAW || state_q == ST_ALPHA);

  pidfd_mul #(.MW(MW), .FB(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pidfd_div #(.NW(W), .DW(W + 1), .FB(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    kp_d = kp_q; ki_d = ki_q; kd_d = kd_q;
    olo_d = olo_q; ohi_d = ohi_q; ilo_d = ilo_q; ihi_d = ihi_q; tau_d = tau_q;
    integ_d = integ_q; deriv_d = deriv_q; prev_d = prev_q; last_d = last_q; pv_d = pv_q;
    smp_d = smp_q; dt_d = dt_q; err_d = err_q; alpha_d = alpha_q; raw_d = raw_q;
    sum_d = sum_q; held_d = held_q; run_d = run_q; state_d = state_q;
    ovalid_d = ovalid_q; oword_d = oword_q;
    acc_w = '0;

    if (mul_start || div_start) run_d = 1'b1;
    if (mul_done || div_done) run_d = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PROP_GAIN:  kp_d = cfg_val;
        REG_INTEG_GAIN: ki_d = cfg_val;
        REG_DERIV_GAIN: kd_d = cfg_val;
        REG_OUT_LOWER: begin
          olo_d  = cfg_val;
          last_d = W'(clamp_wide(SUM_W'(last_q), SUM_W'(cfg_val), SUM_W'(ohi_q)));
        end
        REG_OUT_UPPER: begin
          ohi_d  = cfg_val;
          last_d = W'(clamp_wide(SUM_W'(last_q), SUM_W'(olo_q), SUM_W'(cfg_val)));
        end
        REG_INTEG_LOWER: begin
          ilo_d   = cfg_val;
          integ_d = W'(clamp_wide(SUM_W'(integ_q), SUM_W'(cfg_val), SUM_W'(ihi_q)));
        end
        REG_INTEG_UPPER: begin
          ihi_d   = cfg_val;
          integ_d = W'(clamp_wide(SUM_W'(integ_q), SUM_W'(ilo_q), SUM_W'(cfg_val)));
        end
        REG_FILTER_TAU: tau_d = cfg_data_i;
        default: begin
        end
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          smp_d = in_word_i.sample;
          dt_d  = in_word_i.step_time;
          err_d = $signed({in_word_i.target[W-1], in_word_i.target}) -
                  $signed({in_word_i.sample[W-1], in_word_i.sample});
          if (in_word_i.clear_state) begin
            integ_d = '0;
            deriv_d = '0;
            prev_d  = '0;
            pv_d    = 1'b0;
            last_d  = W'(clamp_wide('0, SUM_W'(olo_q), SUM_W'(ohi_q)));
          end
          if (in_word_i.target_changed) begin
            prev_d = '0;
            pv_d   = 1'b0;
          end
          if (in_word_i.step_time == '0) begin
            held_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            held_d  = 1'b0;
            state_d = ST_INTEG;
          end
        end
      end
      ST_INTEG: begin
        if (mul_done) begin
          acc_w   = SUM_W'(integ_q) + mul_res;
          integ_d = W'(clamp_wide(acc_w, SUM_W'(ilo_q), SUM_W'(ihi_q)));
          if (pv_q) begin
            state_d = ST_RAW;
          end else begin
            raw_d = '0;
            if (tau_q != '0) begin
              state_d = ST_ALPHA;
            end else begin
              deriv_d = '0;
              state_d = ST_PROP;
            end
          end
        end
      end
      ST_RAW: begin
        if (div_done) begin
          raw_d = raw_val;
          if (tau_q != '0) begin
            state_d = ST_ALPHA;
          end else begin
            deriv_d = raw_val;
            state_d = ST_PROP;
          end
        end
      end
      ST_ALPHA: begin
        if (div_done) begin
          alpha_d = $signed(div_quo[W:0]);
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        if (mul_done) begin
          acc_w   = SUM_W'(deriv_q) + mul_res;
          deriv_d = acc_w[W-1:0];
          state_d = ST_PROP;
        end
      end
      ST_PROP: begin
        if (mul_done) begin
          sum_d   = mul_res;
          state_d = ST_INTG;
        end
      end
      ST_INTG: begin
        if (mul_done) begin
          sum_d   = sum_q + mul_res;
          state_d = ST_DERV;
        end
      end
      ST_DERV: begin
        if (mul_done) begin
          acc_w   = sum_q + mul_res;
          last_d  = W'(clamp_wide(acc_w, SUM_W'(olo_q), SUM_W'(ohi_q)));
          prev_d  = smp_q;
          pv_d    = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          oword_d.drive = last_q;
          oword_d.held  = held_q;
          ovalid_d      = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      olo_q    <= {1'b1, {(W-1){1'b0}}};
      ohi_q    <= {1'b0, {(W-1){1'b1}}};
      ilo_q    <= {1'b1, {(W-1){1'b0}}};
      ihi_q    <= {1'b0, {(W-1){1'b1}}};
      tau_q    <= '0;
      integ_q  <= '0;
      deriv_q  <= '0;
      prev_q   <= '0;
      last_q   <= '0;
      pv_q     <= 1'b0;
      run_q    <= 1'b0;
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      kp_q     <= kp_d;
      ki_q     <= ki_d;
      kd_q     <= kd_d;
      olo_q    <= olo_d;
      ohi_q    <= ohi_d;
      ilo_q    <= ilo_d;
      ihi_q    <= ihi_d;
      tau_q    <= tau_d;
      integ_q  <= integ_d;
      deriv_q  <= deriv_d;
      prev_q   <= prev_d;
      last_q   <= last_d;
      pv_q     <= pv_d;
      run_q    <= run_d;
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    dt_q    <= dt_d;
    err_q   <= err_d;
    alpha_q <= alpha_d;
    raw_q   <= raw_d;
    sum_q   <= sum_d;
    held_q  <= held_d;
    oword_q <= oword_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_word_o  = oword_q;

endmodule

>>> design/pidfd_mul.sv
// serial-parallel multiplier, one multiplier bit per cycle, fixed-point rescale
// and saturation of the magnitude; depends on pidfd_pkg
module pidfd_mul import pidfd_pkg::*; #(
  parameter int MW = DATA_W + 1,
  parameter int FB = FRAC_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [MW-1:0]    a_i,
  input  logic signed [MW-1:0]    b_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] res_o
);

  localparam int CW = $clog2(MW);
  localparam int PW = (2 * MW > SUM_W) ? 2 * MW : SUM_W;

  logic [MW-1:0]   mcand_q, mcand_d;
  logic [2*MW-1:0] prod_q, prod_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [MW-1:0]   mag_a, mag_b;
  logic [MW:0]     part;
  logic [PW-1:0]   shifted, lim;
  logic [SUM_W-1:0] mag_r;

  assign mag_a = a_i[MW-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[MW-1] ? (~b_i + 1'b1) : b_i;
  assign part  = {1'b0, prod_q[2*MW-1:MW]} + {1'b0, (prod_q[0] ? mcand_q : {MW{1'b0}})};

  always_comb begin
    mcand_d = mcand_q;
    prod_d  = prod_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    if (start_i) begin
      mcand_d = mag_a;
      prod_d  = {{MW{1'b0}}, mag_b};
      cnt_d   = '0;
      busy_d  = 1'b1;
      neg_d   = a_i[MW-1] ^ b_i[MW-1];
    end else if (busy_q) begin
      prod_d = {part, prod_q[MW-1:1]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(MW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
  end

  assign shifted = PW'(prod_q) >> FB;
  assign lim     = PW'(WIDE_LIM);
  assign mag_r   = (shifted > lim) ? WIDE_LIM : shifted[SUM_W-1:0];
  assign res_o   = neg_q ? -$signed(mag_r) : $signed(mag_r);
  assign done_o  = done_q;

endmodule

>>> design/pidfd_div.sv
// restoring divider, one quotient bit per cycle, dividend pre-scaled by the
// fraction bits; depends on pidfd_pkg
module pidfd_div import pidfd_pkg::*; #(
  parameter int NW = DATA_W,
  parameter int DW = DATA_W + 1,
  parameter int FB = FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NW-1:0]      num_i,
  input  logic [DW-1:0]      den_i,
  output logic               done_o,
  output logic [NW+FB-1:0]   quo_o
);

  localparam int QW = NW + FB;
  localparam int CW = $clog2(QW);

  logic [QW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   r_sh, r_sub;
  logic          ge;

  assign r_sh  = {rem_q, dvd_q[QW-1]};
  assign r_sub = r_sh - {1'b0, den_q};
  assign ge    = (r_sh >= {1'b0, den_q});

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = {num_i, {FB{1'b0}}};
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[QW-2:0], 1'b0};
      quo_d = {quo_q[QW-2:0], ge};
      rem_d = ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> tb/tb_pid_controller_filtered_derivative.sv
// self-checking testbench for pid_controller_filtered_derivative: directed table, then random
// steps under changing settings; the first five rows are checked against fixed words,
// all others against a fixed-point pid predictor; depends on pidfd_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_pid_controller_filtered_derivative;
  import pidfd_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] RAW_LIM = 64'h0000_0000_7fff_ffff;

  typedef struct {
    in_word_t  w;
    bit        fixed;
    out_word_t res;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // controller model state and settings
  longint kp, ki, kd, out_lo, out_hi, int_lo, int_hi;
  logic [63:0] tau;
  longint acc_integ, acc_deriv, last_meas, drive_q;
  bit meas_valid;

  out_word_t pending_drives[$];
  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  bit hold_rx = 0;

  pid_controller_filtered_derivative u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint bound_to(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // (a*b) >> FRAC toward zero, magnitude saturated
  function automatic longint mul_q(longint a, longint b, logic [63:0] lim);
    logic [127:0] p;
    logic [63:0] r;
    p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
    p = p >> FRAC;
    r = (p > {64'b0, lim}) ? lim : p[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // (num << FRAC) / den toward zero, magnitude saturated
  function automatic longint div_q(longint num, logic [63:0] den, logic [63:0] lim);
    logic [127:0] q;
    logic [63:0] r;
    if (den == 0) begin
      r = lim;
    end else begin
      q = ({64'b0, magnitude(num)} << FRAC) / {64'b0, den};
      r = (q > {64'b0, lim}) ? lim : q[63:0];
    end
    return (num < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void clear_ctrl();
    acc_integ = 0;
    acc_deriv = 0;
    last_meas = 0;
    meas_valid = 0;
    drive_q = bound_to(0, out_lo, out_hi);
  endfunction

  function automatic void settings_reset();
    kp = 0; ki = 0; kd = 0;
    out_lo = -64'sd2147483648; out_hi = 64'sd2147483647;
    int_lo = -64'sd2147483648; int_hi = 64'sd2147483647;
    tau = 0;
    clear_ctrl();
  endfunction

  function automatic void apply_setting(cfg_reg_e idx, logic [31:0] d);
    longint s;
    s = longint'($signed(d));
    case (idx)
      REG_PROP_GAIN: kp = s;
      REG_INTEG_GAIN: ki = s;
      REG_DERIV_GAIN: kd = s;
      REG_OUT_LOWER: begin
        out_lo = s;
        drive_q = bound_to(drive_q, out_lo, out_hi);
      end
      REG_OUT_UPPER: begin
        out_hi = s;
        drive_q = bound_to(drive_q, out_lo, out_hi);
      end
      REG_INTEG_LOWER: begin
        int_lo = s;
        acc_integ = bound_to(acc_integ, int_lo, int_hi);
      end
      REG_INTEG_UPPER: begin
        int_hi = s;
        acc_integ = bound_to(acc_integ, int_lo, int_hi);
      end
      REG_FILTER_TAU: tau = {32'b0, d};
      default: ;
    endcase
  endfunction

  function automatic out_word_t pid_step(in_word_t w);
    longint meas, err, raw, alpha, total;
    logic [63:0] dt;
    out_word_t r;
    meas = longint'($signed(w.sample));
    dt = {32'b0, w.step_time};
    if (w.clear_state) clear_ctrl();
    if (w.target_changed) begin
      meas_valid = 0;
      last_meas = 0;
    end
    r.held = 1'b0;
    if (dt == 0) begin
      r.held = 1'b1;
    end else begin
      err = longint'($signed(w.target)) - meas;
      acc_integ = bound_to(acc_integ + mul_q(err, longint'(dt), WIDE_LIM), int_lo, int_hi);
      raw = meas_valid ? div_q(last_meas - meas, dt, RAW_LIM) : 0;
      if (tau > 0) begin
        alpha = div_q(longint'(dt), tau + dt, WIDE_LIM);
        acc_deriv = acc_deriv + mul_q(alpha, raw - acc_deriv, WIDE_LIM);
      end else begin
        acc_deriv = raw;
      end
      total = mul_q(kp, err, WIDE_LIM) + mul_q(ki, acc_integ, WIDE_LIM)
            + mul_q(kd, acc_deriv, WIDE_LIM);
      drive_q = bound_to(total, out_lo, out_hi);
      last_meas = meas;
      meas_valid = 1;
    end
    r.drive = drive_q[31:0];
    return r;
  endfunction

  function automatic in_word_t mk(logic [31:0] s, logic [31:0] dt, logic [31:0] t,
                                  bit tc, bit cs);
    in_word_t w;
    w.sample = s;
    w.step_time = dt;
    w.target = t;
    w.target_changed = tc;
    w.clear_state = cs;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    w = mk($urandom, $urandom, $urandom, $urandom_range(9) == 0, $urandom_range(19) == 0);
    pick = $urandom_range(99);
    if (pick < 75) begin
      w.target = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      w.sample = w.target + $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
      w.step_time = $urandom_range(32'h0002_0000, 1);
    end
    if ($urandom_range(24) == 0) w.step_time = '0;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        report_mismatch("unexpected word", out_word.drive, '0);
      end else begin
        want = pending_drives.pop_front();
        if (out_word.drive !== want.drive) report_mismatch("drive", out_word.drive, want.drive);
        if (out_word.held !== want.held)
          report_mismatch("held", 32'(out_word.held), 32'(want.held));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_rx = 0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_word(in_word_t w, bit fixed, out_word_t res);
    out_word_t want;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready);
    want = pid_step(w);
    pending_drives.push_back(fixed ? res : want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk_i); while (!cfg_ready);
    apply_setting(idx, d);
  endtask

  task automatic write_all(logic [31:0] g0, logic [31:0] g1, logic [31:0] g2,
                           logic [31:0] olo, logic [31:0] ohi, logic [31:0] ilo,
                           logic [31:0] ihi, logic [31:0] tc);
    drain();
    write_reg(REG_PROP_GAIN, g0);
    write_reg(REG_INTEG_GAIN, g1);
    write_reg(REG_DERIV_GAIN, g2);
    write_reg(REG_OUT_LOWER, olo);
    write_reg(REG_OUT_UPPER, ohi);
    write_reg(REG_INTEG_LOWER, ilo);
    write_reg(REG_INTEG_UPPER, ihi);
    write_reg(REG_FILTER_TAU, tc);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    step_row_t rows[17];
    int n;
    settings_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: zero gains give zero drive, zero step_time is held
    rows[0] = '{mk(32'h0001_0000, 32'h0, 32'h0, 0, 0), 1, '{32'h0, 1'b1}};
    rows[1] = '{mk(32'h7fff_ffff, 32'h1, 32'h8000_0000, 0, 0), 1, '{32'h0, 1'b0}};
    rows[2] = '{mk(32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 0, 0), 1, '{32'h0, 1'b0}};
    rows[3] = '{mk(32'h0, 32'h0, 32'h0, 0, 1), 1, '{32'h0, 1'b1}};
    rows[4] = '{mk(32'h1234_5678, 32'h0001_0000, 32'h0, 1, 0), 1, '{32'h0, 1'b0}};
    // with gains and filter set
    rows[5] = '{mk(32'h0001_0000, 32'h0000_4000, 32'h0003_0000, 0, 0), 0, '0};
    rows[6] = '{mk(32'h0002_0000, 32'h0000_4000, 32'h0003_0000, 0, 0), 0, '0};
    rows[7] = '{mk(32'h7fff_ffff, 32'h1, 32'h0, 0, 0), 0, '0};
    rows[8] = '{mk(32'h8000_0000, 32'h1, 32'h7fff_ffff, 0, 0), 0, '0};
    rows[9] = '{mk(32'h0, 32'hffff_ffff, 32'h8000_0000, 0, 0), 0, '0};
    rows[10] = '{mk(32'hffff_0000, 32'h0, 32'h0001_0000, 0, 0), 0, '0};
    rows[11] = '{mk(32'h0005_0000, 32'h0001_0000, 32'h0, 1, 0), 0, '0};
    rows[12] = '{mk(32'h0004_0000, 32'h0001_0000, 32'h0, 0, 0), 0, '0};
    rows[13] = '{mk(32'h0004_0000, 32'h0, 32'h0, 1, 1), 0, '0};
    rows[14] = '{mk(32'h0003_0000, 32'h0000_8000, 32'h0, 0, 1), 0, '0};
    rows[15] = '{mk(32'h0001_0000, 32'h0000_8000, 32'h0, 1, 1), 0, '0};
    rows[16] = '{mk(32'h0, 32'h0000_0001, 32'h0000_0001, 0, 0), 0, '0};

    for (int i = 0; i < 17; i++) begin
      if (i == 5)
        write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'hff9c_0000,
                  32'h0064_0000, 32'hffce_0000, 32'h0032_0000, 32'h0000_8000);
      send_word(rows[i].w, rows[i].fixed, rows[i].res);
    end

    n = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        1: write_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0010_0000,
                     32'hfff0_0000, 32'h0001_0000, 32'hffff_0000, 32'h0);
        default: write_all($urandom_range(32'h0004_0000), $urandom_range(32'h0002_0000),
                           $urandom_range(32'h0001_0000),
                           32'hff00_0000 | $urandom_range(32'h00ff_ffff),
                           $urandom_range(32'h00ff_ffff),
                           32'hff00_0000 | $urandom_range(32'h00ff_ffff),
                           $urandom_range(32'h00ff_ffff),
                           $urandom_range(1) ? $urandom_range(32'h0004_0000) : 32'h0);
      endcase
      for (int k = 0; k < 100; k++) begin
        if (n < 170) begin
          tx_idle = 28; rx_idle = 86;
        end else if (n < 340) begin
          tx_idle = 86; rx_idle = 28;
        end else begin
          tx_idle = 0; rx_idle = 0;
        end
        if (n == 420) hold_rx = 1;
        if (n == 460) drain();
        send_word(random_word(), 0, '0);
        n++;
      end
    end

    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pidfd_pkg.sv
design/pidfd_mul.sv
design/pidfd_div.sv
design/pid_controller_filtered_derivative.sv
tb/tb_pid_controller_filtered_derivative.sv
